@@ design/assert_macros.svh @@
// assertion macros used by the top level of the sorted priority queue rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge out of reset
`define SPQ_ASSERT(lbl, c, r, prop) \
    lbl: assert property (@(posedge c) disable iff (!r) (prop)) \
        else $error("spq assertion failed");

// property that must hold in the cycle after the trigger
`define SPQ_ASSERT_NEXT(lbl, c, r, trig, prop) \
    lbl: assert property (@(posedge c) disable iff (!r) (trig) |=> (prop)) \
        else $error("spq assertion failed");

`else

`define SPQ_ASSERT(lbl, c, r, prop)
`define SPQ_ASSERT_NEXT(lbl, c, r, trig, prop)

`endif

`endif

@@ design/spq_pkg.sv @@
// types and constants of the sorted priority queue
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int DEPTH_DEFAULT = 8;
    localparam int VAL_W         = 32;
    localparam int PRI_W         = 8;
    localparam int COUNT_W       = 7;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    localparam logic [1:0] ST_ENQUEUED = 2'd0;
    localparam logic [1:0] ST_DEQUEUED = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef logic signed [VAL_W-1:0] spq_value_t;
    typedef logic [PRI_W-1:0]        spq_pri_t;

    // operation broadcast to every cell
    typedef struct packed {
        logic       enq;
        logic       deq;
        spq_pri_t   pri;
        spq_value_t val;
    } spq_op_t;

endpackage

`default_nettype wire

@@ design/spq_cell.sv @@
// one slot of the sorted shift-register array
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
    input  wire logic               clk,
    input  wire spq_pkg::spq_op_t   op,
    input  wire logic               occupied,
    input  wire logic               left_behind,
    input  wire spq_pkg::spq_pri_t  left_pri,
    input  wire spq_pkg::spq_value_t left_val,
    input  wire spq_pkg::spq_pri_t  right_pri,
    input  wire spq_pkg::spq_value_t right_val,
    output logic                    behind,
    output spq_pkg::spq_pri_t       pri,
    output spq_pkg::spq_value_t     val
);
    import spq_pkg::*;

    spq_pri_t   pri_reg;
    spq_pri_t   pri_next;
    spq_value_t val_reg;
    spq_value_t val_next;

    // new entry stays behind this slot when it holds an equal or higher priority
    assign behind = occupied && (pri_reg >= op.pri);

    always_comb
    begin
        pri_next = pri_reg;
        val_next = val_reg;
        if (op.enq && !behind)
        begin
            if (left_behind)
            begin
                pri_next = op.pri;
                val_next = op.val;
            end
            else
            begin
                pri_next = left_pri;
                val_next = left_val;
            end
        end
        else if (op.deq)
        begin
            pri_next = right_pri;
            val_next = right_val;
        end
    end

    always_ff @(posedge clk)
    begin
        pri_reg <= pri_next;
        val_reg <= val_next;
    end

    assign pri = pri_reg;
    assign val = val_reg;

endmodule

`default_nettype wire

@@ design/sorted_priority_queue_top.sv @@
// sorted priority queue: row of shifting cells plus occupancy and result register
// latency: result is valid the cycle after the input transaction is accepted
// throughput: one transaction per cycle unless a held result stalls the input;
//   every cell updates together from its own compare and its neighbors' contents
// reset: clears occupancy and result valid; entry storage is not cleared
// input ready stays high while the result register is empty or being drained
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sorted_priority_queue_top #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                cmd,
    input  wire spq_pkg::spq_value_t value_in,
    input  wire spq_pkg::spq_pri_t   priority_in,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output spq_pkg::spq_value_t      value_out,
    output logic [1:0]               status,
    output logic [spq_pkg::COUNT_W-1:0] count
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    // occupancy of the cell row
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // result register
    logic                out_valid_reg;
    logic                out_valid_next;
    spq_value_t          value_out_reg;
    spq_value_t          value_out_next;
    logic [1:0]          status_reg;
    logic [1:0]          status_next;
    logic [COUNT_W-1:0]  count_out_reg;
    logic [COUNT_W-1:0]  count_out_next;

    logic     accept;
    logic     is_full;
    logic     is_empty;
    spq_op_t  op;

    // per-cell contents and compare flags
    logic [DEPTH-1:0]             occupied;
    logic [DEPTH-1:0]             behind;
    spq_pri_t   [DEPTH-1:0]       pri_q;
    spq_value_t [DEPTH-1:0]       val_q;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);

    // operation broadcast; refused enqueue and empty dequeue leave the row untouched
    assign op.enq = accept && (cmd == CMD_ENQ) && !is_full;
    assign op.deq = accept && (cmd == CMD_DEQ) && !is_empty;
    assign op.pri = priority_in;
    assign op.val = value_in;

    // cell row: entries sorted highest priority first, head in cell 0
    // enqueue shifts the tail one step right, dequeue shifts everything left
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic       left_behind;
        spq_pri_t   left_pri;
        spq_value_t left_val;
        spq_pri_t   right_pri;
        spq_value_t right_val;

        assign occupied[i] = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_head
            // head cell takes the new entry whenever it does not stay ahead of it
            assign left_behind = 1'b1;
            assign left_pri    = priority_in;
            assign left_val    = value_in;
        end
        else
        begin : g_body
            assign left_behind = behind[i-1];
            assign left_pri    = pri_q[i-1];
            assign left_val    = val_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            // nothing beyond the tail; its content becomes don't-care on dequeue
            assign right_pri = pri_q[i];
            assign right_val = val_q[i];
        end
        else
        begin : g_mid
            assign right_pri = pri_q[i+1];
            assign right_val = val_q[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .op          (op),
            .occupied    (occupied[i]),
            .left_behind (left_behind),
            .left_pri    (left_pri),
            .left_val    (left_val),
            .right_pri   (right_pri),
            .right_val   (right_val),
            .behind      (behind[i]),
            .pri         (pri_q[i]),
            .val         (val_q[i])
        );
    end

    // occupancy and result for the accepted transaction
    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        value_out_next = value_out_reg;
        status_next    = status_reg;
        count_out_next = count_out_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            out_valid_next = 1'b1;
            value_out_next = '0;
            if (cmd == CMD_ENQ)
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next  = count_reg + CNT_W'(1);
                    status_next = ST_ENQUEUED;
                end
            end
            else
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    count_next     = count_reg - CNT_W'(1);
                    status_next    = ST_DEQUEUED;
                    value_out_next = val_q[0];
                end
            end
            count_out_next = COUNT_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload needs no reset
    always_ff @(posedge clk)
    begin
        value_out_reg <= value_out_next;
        status_reg    <= status_next;
        count_out_reg <= count_out_next;
    end

    assign out_valid = out_valid_reg;
    assign value_out = value_out_reg;
    assign status    = status_reg;
    assign count     = count_out_reg;

    // checks
    `SPQ_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(DEPTH))
    `SPQ_ASSERT(a_head_sorted, clk, rst_n, (count_reg < CNT_W'(2)) || (pri_q[0] >= pri_q[1]))
    `SPQ_ASSERT_NEXT(a_enq_grows, clk, rst_n, op.enq, count_reg == $past(count_reg) + CNT_W'(1))
    `SPQ_ASSERT_NEXT(a_deq_head, clk, rst_n, op.deq, (value_out == $past(val_q[0])) && (status == ST_DEQUEUED))

endmodule

`default_nettype wire

@@ tb/spq_checker.sv @@
// transaction checker for the sorted priority queue: shadow queue, expected results, compare
`timescale 1ns / 1ps

module spq_checker #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic                              cmd,
    input  spq_pkg::spq_value_t               value_in,
    input  spq_pkg::spq_pri_t                 priority_in,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  spq_pkg::spq_value_t               value_out,
    input  logic [1:0]                        status,
    input  logic [spq_pkg::COUNT_W-1:0]       count,
    output int                                fail_count,
    output int                                outstanding
);
    import spq_pkg::*;

    typedef struct {
        spq_value_t               value;
        logic [1:0]               st;
        logic [COUNT_W-1:0]       cnt;
    } queue_result_t;

    // shadow copy of the sorted entries, head at slot 0
    spq_value_t    shadow_values [DEPTH];
    spq_pri_t      shadow_pris [DEPTH];
    int            shadow_count = 0;
    queue_result_t pending_results [$];

    // applies one operation to the shadow queue and returns its result
    function automatic queue_result_t predict_queue_op(logic op, spq_value_t val, spq_pri_t pri);
        queue_result_t r;
        int            pos;
        r.value = '0;
        if (op == CMD_ENQ)
        begin
            if (shadow_count >= DEPTH)
            begin
                r.st  = ST_FULL;
                r.cnt = COUNT_W'(DEPTH);
            end
            else
            begin
                // new entry goes behind every entry of equal or higher priority
                pos = shadow_count;
                for (int i = shadow_count - 1; i >= 0; i--)
                    if (shadow_pris[i] < pri)
                        pos = i;
                for (int i = shadow_count; i > pos; i--)
                begin
                    shadow_values[i] = shadow_values[i-1];
                    shadow_pris[i]   = shadow_pris[i-1];
                end
                shadow_values[pos] = val;
                shadow_pris[pos]   = pri;
                shadow_count++;
                r.st  = ST_ENQUEUED;
                r.cnt = COUNT_W'(shadow_count);
            end
        end
        else if (shadow_count == 0)
        begin
            r.st  = ST_EMPTY;
            r.cnt = '0;
        end
        else
        begin
            r.value = shadow_values[0];
            for (int i = 1; i < shadow_count; i++)
            begin
                shadow_values[i-1] = shadow_values[i];
                shadow_pris[i-1]   = shadow_pris[i];
            end
            shadow_count--;
            r.st  = ST_DEQUEUED;
            r.cnt = COUNT_W'(shadow_count);
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        queue_result_t exp_r;
        if (!rst_n)
        begin
            shadow_count = 0;
            pending_results.delete();
            outstanding = 0;
            fail_count  = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                pending_results.push_back(predict_queue_op(cmd, value_in, priority_in));
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result value %0d status %0d count %0d",
                                 $time, value_out, status, count);
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (value_out !== exp_r.value || status !== exp_r.st
                        || count !== exp_r.cnt)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: expected %0d/%0d/%0d got %0d/%0d/%0d",
                                     $time, exp_r.value, exp_r.st, exp_r.cnt,
                                     value_out, status, count);
                    end
                end
            end
            outstanding = pending_results.size();
        end
    end

endmodule

@@ tb/sorted_priority_queue_top_tb.sv @@
// testbench top for the sorted priority queue: clock, reset, stimulus, idling and verdict
`timescale 1ns / 1ps

module sorted_priority_queue_top_tb;
    import spq_pkg::*;

    localparam int QDEPTH         = DEPTH_DEFAULT;
    // cycles with no transaction on either channel before the run is abandoned
    localparam int STALL_LIMIT    = 5000;
    // length of the long receiver hold-off
    localparam int HOLD_OFF_LEN   = 60;
    localparam int PHASE_ITEMS    = 405;

    logic                clk;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_ready;
    logic                cmd         = CMD_ENQ;
    spq_value_t          value_in    = '0;
    spq_pri_t            priority_in = '0;
    logic                out_valid;
    logic                out_ready   = 1'b0;
    spq_value_t          value_out;
    logic [1:0]          status;
    logic [COUNT_W-1:0]  count;

    int mismatch_total;
    int results_outstanding;

    // idling knobs, percent of cycles
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // request for a long receiver hold-off, taken up by the receiver process
    bit hold_off_req   = 1'b0;
    int hold_off_left  = 0;
    int quiet_cycles   = 0;

    sorted_priority_queue_top #(
        .DEPTH(QDEPTH)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .value_in    (value_in),
        .priority_in (priority_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .value_out   (value_out),
        .status      (status),
        .count       (count)
    );

    spq_checker #(
        .DEPTH(QDEPTH)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .value_in    (value_in),
        .priority_in (priority_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .value_out   (value_out),
        .status      (status),
        .count       (count),
        .fail_count  (mismatch_total),
        .outstanding (results_outstanding)
    );

    // 100 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side: random stalls, or a long hold-off when asked for one
    always @(negedge clk)
    begin
        if (hold_off_req)
        begin
            hold_off_req  = 1'b0;
            hold_off_left = HOLD_OFF_LEN;
        end
        if (hold_off_left > 0)
        begin
            hold_off_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog: counts cycles in which no transaction moves on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // offers one transaction, with random idle cycles ahead of it, and
    // returns at the falling edge after it was accepted
    task automatic send_txn(input logic op, input spq_value_t val, input spq_pri_t pri);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= op;
        value_in    <= val;
        priority_in <= pri;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // random traffic in segments that lean toward filling or draining,
    // so the queue sweeps between empty and full and hits both refusals
    task automatic send_random(input int n);
        int        enq_pct;
        logic      op;
        spq_pri_t  pri;
        enq_pct = 50;
        for (int k = 0; k < n; k++)
        begin
            if (k % 24 == 0)
            begin
                case ($urandom_range(2))
                    0: enq_pct = 85;
                    1: enq_pct = 15;
                    default: enq_pct = 50;
                endcase
            end
            op = ($urandom_range(99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
            // few distinct priorities give lots of ties, the rest spread wide
            case ($urandom_range(3))
                0: pri = spq_pri_t'($urandom_range(3));
                1: pri = $urandom_range(1) ? 8'hFF : 8'h00;
                default: pri = spq_pri_t'($urandom);
            endcase
            send_txn(op, spq_value_t'($urandom), pri);
        end
    endtask

    initial
    begin
        // reset held low from the start, released at a falling edge
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty dequeue, field extremes, ties, full refusal, full drain
        send_txn(CMD_DEQ, 32'sh7FFF_FFFF, 8'hFF);
        send_txn(CMD_ENQ, 32'sh7FFF_FFFF, 8'hFF);
        send_txn(CMD_ENQ, 32'sh8000_0000, 8'h00);
        send_txn(CMD_ENQ, 32'sh0000_0000, 8'hFF);
        send_txn(CMD_ENQ, -32'sd1, 8'h80);
        for (int i = 0; i < QDEPTH - 4; i++)
            send_txn(CMD_ENQ, spq_value_t'(i + 1), 8'h80);
        send_txn(CMD_ENQ, 32'sd12345, 8'hFF);
        send_txn(CMD_ENQ, 32'sh5555_AAAA, 8'h00);
        for (int i = 0; i < QDEPTH; i++)
            send_txn(CMD_DEQ, spq_value_t'($urandom), spq_pri_t'($urandom));
        send_txn(CMD_DEQ, 32'sh0000_0000, 8'h00);

        // no idling, with a long hold-off on the result side while the
        // input keeps offering transactions until it backs up
        hold_off_req = 1'b1;
        send_random(30);
        send_random(PHASE_ITEMS - 30);

        // sender idle most of the time
        send_idle_pct  = 70;
        recv_stall_pct = 0;
        send_random(PHASE_ITEMS);

        // receiver stalling most of the time
        send_idle_pct  = 0;
        recv_stall_pct = 70;
        send_random(PHASE_ITEMS);

        // both sides idling
        send_idle_pct  = 24;
        recv_stall_pct = 24;
        send_random(PHASE_ITEMS);

        // drain: stop offering, let every result come back
        in_valid       <= 1'b0;
        recv_stall_pct = 0;
        do
            @(negedge clk);
        while (results_outstanding != 0);
        repeat (5) @(negedge clk);

        if (mismatch_total == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
